// File: hw/rtl/por_pkg.sv
// Shared types and constants for the port owner registry.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package por_pkg;

	// Table geometry
	localparam int PORT_COUNT = 1024;
	localparam int AW         = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int ENTRY_W    = 33;   // used bit over {process, thread}

	// Operation codes
	localparam logic [1:0] FN_REG  = 2'd0;
	localparam logic [1:0] FN_REL  = 2'd1;
	localparam logic [1:0] FN_LOOK = 2'd2;
	localparam logic [1:0] FN_ALL  = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_PORT  = 3'd1;
	localparam logic [2:0] ST_TAKEN     = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_NOT_OWNER = 3'd4;

	// Controller to datapath
	typedef struct packed {
		logic cap;       // capture the accepted transaction
		logic rd_port;   // read the entry of the incoming port
		logic sweep_rd;  // read the entry at the sweep counter
		logic clr_wr;    // clear the entry at the sweep counter
		logic cnt_clr;   // restart the sweep counter
		logic ev_fire;   // finish the operation and load the result
	} por_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cnt_last;  // counter sits on the last entry
		logic out_free;  // result register can take a new result
	} por_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/port_owner_registry.sv
// Port owner registry: register, release, look up, and release all ports of a caller.
// Register, release and lookup: the entry is read on acceptance, evaluated and the result registered;
// release-all: a read/compare/write sweep over the table, a drain state, then the result. No new
// transaction is taken until the result is loaded. The table allows one read and one write per cycle.
// After reset a clearing pass over every entry empties every port; input stalls meanwhile.
// Instantiates por_ctrl and por_dpath; depends on por_pkg.
`default_nettype none

module port_owner_registry
	import por_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] port,
	input  wire logic [15:0] caller_proc,
	input  wire logic [15:0] caller_thread,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      owner_proc,
	output logic [15:0]      owner_thread
);

	por_cmd_t cmd;
	por_sts_t sts;

	// Sequence each transaction
	por_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Table, evaluation and result register
	por_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.port          (port),
		.caller_proc   (caller_proc),
		.caller_thread (caller_thread),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.owner_proc    (owner_proc),
		.owner_thread  (owner_thread)
	);

endmodule

`default_nettype wire

// File: hw/rtl/por_ctrl.sv
// Controller state machine for the port owner registry.
// Depends on por_pkg for command and status structs and operation codes.
`default_nettype none

module por_ctrl
	import por_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] func,
	output logic            in_stall,
	output por_cmd_t        cmd,
	input  wire por_sts_t   sts
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SWEEP = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Decode commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = 1'b1;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.cnt_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap = 1'b1;
					if (func == FN_ALL) begin
						cmd.cnt_clr = 1'b1;
						state_nxt   = S_SWEEP;
					end else begin
						cmd.rd_port = 1'b1;
						state_nxt   = S_EVAL;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (sts.cnt_last)
					state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				// last compare and write back happen here
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				if (sts.out_free) begin
					cmd.ev_fire = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Advance state; start with the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR;
		else
			state_q <= state_nxt;
	end

endmodule

`default_nettype wire

// File: hw/rtl/por_dpath.sv
// Datapath for the port owner registry: owner table memory, sweep counter,
// operation evaluation and result register. Depends on por_pkg.
`default_nettype none

module por_dpath
	import por_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire por_cmd_t    cmd,
	output por_sts_t         sts,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] port,
	input  wire logic [15:0] caller_proc,
	input  wire logic [15:0] caller_thread,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      owner_proc,
	output logic [15:0]      owner_thread
);

	// Table: used bit in the top bit, then process and thread
	logic [ENTRY_W-1:0] mem [PORT_COUNT];

	// Captured transaction
	logic [1:0]  func_q;
	logic [15:0] port_q;
	logic [15:0] proc_q;
	logic [15:0] thread_q;

	logic [AW-1:0]      cnt_q;
	logic [ENTRY_W-1:0] rd_q;
	logic               sw_v_s1;
	logic [AW-1:0]      wr_idx_s1;

	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [15:0]        owner_proc_q;
	logic [15:0]        owner_thread_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	logic               bad_port;
	logic               used;
	logic               sweep_hit;
	logic [2:0]         ev_status;
	logic [15:0]        ev_proc;
	logic [15:0]        ev_thread;
	logic               ev_wr;
	logic [ENTRY_W-1:0] ev_data;

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q   <= func;
			port_q   <= port;
			proc_q   <= caller_proc;
			thread_q <= caller_thread;
		end
	end

	// Advance the sweep counter, shared by clearing and release-all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.cnt_clr)
			cnt_q <= '0;
		else if (cmd.clr_wr || cmd.sweep_rd)
			cnt_q <= (cnt_q == AW'(PORT_COUNT - 1)) ? '0 : cnt_q + AW'(1);
	end

	// Track which entry the sweep read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sw_v_s1 <= 1'b0;
		else
			sw_v_s1 <= cmd.sweep_rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_rd)
			wr_idx_s1 <= cnt_q;
	end

	// Select the read address
	assign rd_en   = cmd.rd_port || cmd.sweep_rd;
	assign rd_addr = cmd.rd_port ? port[AW-1:0] : cnt_q;

	// Evaluate an operation against the read entry; release-all reports OK
	assign bad_port = {1'b0, port_q} >= 17'(PORT_COUNT);
	assign used     = rd_q[ENTRY_W-1];

	always_comb begin
		ev_status = ST_OK;
		ev_proc   = '0;
		ev_thread = '0;
		ev_wr     = 1'b0;
		ev_data   = rd_q;
		if (func_q == FN_ALL) begin
			ev_status = ST_OK;
		end else if (bad_port) begin
			ev_status = ST_BAD_PORT;
		end else if (func_q == FN_REG) begin
			if (used) begin
				ev_status = ST_TAKEN;
			end else begin
				ev_wr   = 1'b1;
				ev_data = {1'b1, proc_q, thread_q};
			end
		end else if (!used) begin
			ev_status = ST_EMPTY;
		end else if (func_q == FN_REL) begin
			if (rd_q[31:16] != proc_q) begin
				ev_status = ST_NOT_OWNER;
			end else begin
				ev_wr   = 1'b1;
				ev_data = {1'b0, rd_q[31:0]};
			end
		end else begin
			ev_proc   = rd_q[31:16];
			ev_thread = rd_q[15:0];
		end
	end

	// Release-all frees an occupied entry that matches the caller exactly
	assign sweep_hit = sw_v_s1 && used && (rd_q[31:0] == {proc_q, thread_q});

	// Select the write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (sweep_hit) begin
			wr_en   = 1'b1;
			wr_addr = wr_idx_s1;
			wr_data = {1'b0, rd_q[31:0]};
		end else if (cmd.ev_fire && ev_wr) begin
			wr_en   = 1'b1;
			wr_addr = port_q[AW-1:0];
			wr_data = ev_data;
		end
	end

	// Table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.ev_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ev_fire) begin
			status_q       <= ev_status;
			owner_proc_q   <= ev_proc;
			owner_thread_q <= ev_thread;
		end
	end

	assign sts.cnt_last = (cnt_q == AW'(PORT_COUNT - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign owner_proc   = owner_proc_q;
	assign owner_thread = owner_thread_q;

endmodule

`default_nettype wire

// File: hw/rtl/por_chk.sv
// Port-level checker for the port owner registry, bound to the top level.
// Depends on por_pkg for status codes.
`default_nettype none

module por_chk
	import por_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [15:0] owner_proc,
	input wire logic [15:0] owner_thread
);

	// Only one transaction is in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while one is in flight");

	// Status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD_PORT || status == ST_TAKEN ||
			status == ST_EMPTY || status == ST_NOT_OWNER))
		else $error("undefined status code");

	// Owner fields are zero on any failed result
	a_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> owner_proc == 16'd0 && owner_thread == 16'd0)
		else $error("owner fields nonzero on a failed result");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
			$stable(owner_proc) && $stable(owner_thread))
		else $error("stalled result changed");

endmodule

bind port_owner_registry por_chk u_por_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.owner_proc   (owner_proc),
	.owner_thread (owner_thread)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for port_owner_registry: directed tests, then random traffic.
// Depends on por_pkg and the port_owner_registry RTL; needs no files or arguments.

module testbench;
	import por_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int RANDOM_ITEMS = 450;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] proc;
		logic [15:0] thread;
	} reg_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FN_LOOK;
	logic [15:0] port = '0;
	logic [15:0] caller_proc = '0;
	logic [15:0] caller_thread = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] owner_proc;
	logic [15:0] owner_thread;

	// Shadow copy of the port table
	bit          port_busy [PORT_COUNT];
	logic [31:0] port_holder [PORT_COUNT];

	reg_result_t pending_results [$];
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned op_count [4] = '{0, 0, 0, 0};
	int unsigned cycle_count = 0;
	bit          no_idle = 1'b0;

	port_owner_registry dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.port          (port),
		.caller_proc   (caller_proc),
		.caller_thread (caller_thread),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.owner_proc    (owner_proc),
		.owner_thread  (owner_thread)
	);

	initial forever #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("port_owner_registry test failed");
			$finish;
		end
	end

	// Apply one operation to the shadow table and return the result it should give
	function automatic reg_result_t apply_port_op(logic [1:0] fn, logic [15:0] p,
			logic [15:0] pr, logic [15:0] th);
		reg_result_t r;
		logic [31:0] me;
		r = '0;
		r.status = ST_OK;
		me = {pr, th};
		if (fn == FN_ALL) begin
			for (int i = 0; i < PORT_COUNT; i++)
				if (port_busy[i] && port_holder[i] == me)
					port_busy[i] = 1'b0;
		end else if (p >= PORT_COUNT) begin
			r.status = ST_BAD_PORT;
		end else if (fn == FN_REG) begin
			if (port_busy[p]) begin
				r.status = ST_TAKEN;
			end else begin
				port_busy[p] = 1'b1;
				port_holder[p] = me;
			end
		end else if (!port_busy[p]) begin
			r.status = ST_EMPTY;
		end else if (fn == FN_REL) begin
			if (port_holder[p][31:16] != pr)
				r.status = ST_NOT_OWNER;
			else
				port_busy[p] = 1'b0;
		end else begin
			r.proc = port_holder[p][31:16];
			r.thread = port_holder[p][15:0];
		end
		return r;
	endfunction

	// Send one transaction; called right after a rising edge
	task automatic send_op(logic [1:0] fn, logic [15:0] p, logic [15:0] pr, logic [15:0] th);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		port <= p;
		caller_proc <= pr;
		caller_thread <= th;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_port_op(fn, p, pr, th));
		op_count[fn]++;
	endtask

	// Drain the result channel with random back-pressure
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			hold = no_idle ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_result
		reg_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending: status %0d", status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (owner_proc !== want.proc) begin
					$error("owner_proc: expected %0h, actual %0h", want.proc, owner_proc);
					fail_count++;
				end
				if (owner_thread !== want.thread) begin
					$error("owner_thread: expected %0h, actual %0h", want.thread, owner_thread);
					fail_count++;
				end
			end
		end
	end

	// Caller ids from a small pool so that ownership matches often
	function automatic logic [15:0] pick_id();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'h0001;
			4, 5: return 16'h8002;
			default: return 16'($urandom);
		endcase
	endfunction

	// Ports mostly from a small hot set, some at the table edges
	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 15))
			0: return 16'($urandom);
			1: return 16'(PORT_COUNT - 1 - $urandom_range(0, 3));
			2: return 16'(PORT_COUNT + $urandom_range(0, 3));
			default: return 16'($urandom_range(0, 11));
		endcase
	endfunction

	task automatic check_bad_port();
		send_op(FN_REG, 16'(PORT_COUNT), 16'h0001, 16'h0001);
		send_op(FN_REL, 16'hFFFF, 16'h0001, 16'h0001);
		send_op(FN_LOOK, 16'(PORT_COUNT), 16'h0000, 16'h0000);
	endtask

	task automatic check_empty_port();
		send_op(FN_LOOK, 16'h0000, 16'h0000, 16'h0000);
		send_op(FN_REL, 16'(PORT_COUNT - 1), 16'hFFFF, 16'hFFFF);
	endtask

	task automatic check_register_lookup();
		send_op(FN_REG, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_op(FN_LOOK, 16'h0000, 16'h0000, 16'h0000);
		// owner registering again still gets the taken status
		send_op(FN_REG, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_op(FN_REG, 16'(PORT_COUNT - 1), 16'h0000, 16'h0000);
		send_op(FN_LOOK, 16'(PORT_COUNT - 1), 16'hFFFF, 16'hFFFF);
	endtask

	task automatic check_release_rules();
		send_op(FN_REL, 16'h0000, 16'h0000, 16'hFFFF);
		// thread number is not checked on release
		send_op(FN_REL, 16'h0000, 16'hFFFF, 16'h0000);
		send_op(FN_LOOK, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_op(FN_REL, 16'h0000, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic check_release_all();
		send_op(FN_REG, 16'h0001, 16'h0007, 16'h0009);
		send_op(FN_REG, 16'h0002, 16'h0007, 16'h0009);
		send_op(FN_REG, 16'h0003, 16'h0007, 16'h000A);
		// port field is ignored, only an exact caller match is freed
		send_op(FN_ALL, 16'hFFFF, 16'h0007, 16'h0009);
		send_op(FN_LOOK, 16'h0001, 16'h0000, 16'h0000);
		send_op(FN_LOOK, 16'h0003, 16'h0000, 16'h0000);
		send_op(FN_ALL, 16'h0000, 16'h0001, 16'h0001);
		send_op(FN_LOOK, 16'h0003, 16'h0000, 16'h0000);
	endtask

	task automatic run_random_traffic();
		int unsigned target;
		int unsigned n;
		logic [15:0] p;
		logic [15:0] cp;
		logic [15:0] ct;
		int pick;
		target = op_count[0] + op_count[1] + op_count[2] + op_count[3] + RANDOM_ITEMS;
		n = 0;
		while (op_count[0] + op_count[1] + op_count[2] + op_count[3] < target) begin
			// alternate runs with random idling and runs at full rate
			no_idle = ((n / 40) % 3) == 1;
			n++;
			p = pick_port();
			cp = pick_id();
			ct = pick_id();
			if ($urandom_range(0, 9) < 3) begin
				// claim, look up, then give the port back in some way
				send_op(FN_REG, p, cp, ct);
				send_op(FN_LOOK, p, pick_id(), pick_id());
				case ($urandom_range(0, 3))
					0: send_op(FN_REL, p, pick_id(), pick_id());
					1, 2: send_op(FN_REL, p, cp, pick_id());
					default: send_op(FN_ALL, 16'($urandom), cp, ct);
				endcase
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					send_op(FN_ALL, 16'($urandom), cp, ct);
				else if (pick < 8)
					send_op(FN_REG, p, cp, ct);
				else if (pick < 14)
					send_op(FN_REL, p, cp, ct);
				else
					send_op(FN_LOOK, p, cp, ct);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_bad_port();
		check_empty_port();
		check_register_lookup();
		check_release_rules();
		check_release_all();
		run_random_traffic();
		// drop valid, then wait out the results and a full sweep
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PORT_COUNT + 8) @(posedge clk);
		$display("Covered %0d register, %0d release, %0d lookup, %0d release-all transactions;",
			op_count[FN_REG], op_count[FN_REL], op_count[FN_LOOK], op_count[FN_ALL]);
		$display("checked %0d results with random gaps and back-pressure.", results_seen);
		if (fail_count == 0)
			$display("port_owner_registry test passed");
		else
			$display("port_owner_registry test failed");
		$finish;
	end

endmodule
